>>> design/srsm_pkg.sv
// srsm_pkg: constants, types and helper functions for the stream regex matcher.
// Depends on nothing; used by simple_regex_stream_matcher_unit and the bench modules.
package srsm_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
    localparam int WORD_COUNT   = 4;
    localparam int WORD_BYTES   = 8;
    localparam int STORED_BYTES = WORD_COUNT * WORD_BYTES;
    localparam int SCAN_LEVELS  = $clog2(PATTERN_MAX + 1);
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

    // Pattern metacharacters
    localparam logic [7:0] CHAR_ANCHOR_START = 8'h5E; // ^
    localparam logic [7:0] CHAR_ANCHOR_END   = 8'h24; // $
    localparam logic [7:0] CHAR_STAR         = 8'h2A; // *
    localparam logic [7:0] CHAR_ANY          = 8'h2E; // .

    typedef logic [PATTERN_MAX:0]   pos_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [7:0]             byte_t;
    typedef logic [63:0]            word_t;

    // Epsilon closure over starred tokens: position k is reached from k-2
    // when link[k] is set. Solved as a log-depth prefix scan with stride 2.
    function automatic pos_t closure(pos_t set_in, pos_t link);
        pos_t a;
        pos_t p;
        pos_t a_n;
        pos_t p_n;
        int   d;
        a = set_in;
        p = link;
        for (int lv = 0; lv < SCAN_LEVELS; lv++) begin
            d   = 2 << lv;
            a_n = a;
            p_n = p;
            for (int k = 0; k <= PATTERN_MAX; k++) begin
                if (k >= d) begin
                    a_n[k] = a[k] | (p[k] & a[k-d]);
                    p_n[k] = p[k] & p[k-d];
                end
            end
            a = a_n;
            p = p_n;
        end
        return a;
    endfunction

endpackage

>>> design/simple_regex_stream_matcher_unit.sv
// simple_regex_stream_matcher_unit: streaming NFA matcher for '.', 'x*', '^', '$'.
// Depends on srsm_pkg.
//
// Text bytes enter on the s_ stream one item per cycle; the item with s_tlast high
// closes a text and produces one m_ item whose bit 0 says whether the pattern matched
// any substring (an empty pattern always matches). An accepted byte is held in the
// input register, where the position-set update (a log-depth closure scan over the
// pattern positions) runs, and the edge that moves it on loads the state and, for a
// last byte, the result register. The sustained rate is one item per cycle, and the
// result passes through the input register and then the result register. Only the
// last byte of a text can stall, and only while the result register is still full.
// Write configuration only while no text is in flight.
module simple_regex_stream_matcher_unit
    import srsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_char
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] matched, [7:1] zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    // Configuration registers
    logic [5:0] pattern_len_reg;
    word_t      pattern_word_reg [WORD_COUNT];

    // Input register
    logic  in_valid_reg;
    byte_t in_char_reg;
    logic  in_last_reg;

    // Matcher state
    pos_t active_reg, active_next;
    logic start_reg,  start_next;
    logic found_reg,  found_next;

    // Result register
    logic out_valid_reg, out_valid_next;
    logic out_match_reg, out_match_next;

    logic  advance;
    logic  out_free;
    byte_t pb [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] star;
    logic [PATTERN_MAX-1:0] byte_ok;
    len_t  len;
    logic  anchored;
    len_t  base;
    pos_t  link;
    pos_t  cur0, cur, nxt, nxt2, fin_set;
    logic  found_step;
    logic  match_final;
    byte_t tail_byte;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_match_reg};

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg <= '0;
            for (int w = 0; w < WORD_COUNT; w++) pattern_word_reg[w] <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_PATTERN_LEN) begin
                pattern_len_reg <= cfg_data[5:0];
            end else if (cfg_index >= REG_PATTERN_WORD_0 && cfg_index <= REG_PATTERN_WORD_3) begin
                pattern_word_reg[2'(cfg_index - REG_PATTERN_WORD_0)] <= cfg_data;
            end
        end
    end

    // Pattern decode: bytes, star flags, byte compare against current item
    always_comb begin
        len = (pattern_len_reg > 6'(PATTERN_MAX)) ? len_t'(PATTERN_MAX)
                                                   : len_t'(pattern_len_reg);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k < STORED_BYTES)
                pb[k] = pattern_word_reg[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
            else
                pb[k] = '0;
        end
        for (int k = 0; k < PATTERN_MAX; k++) begin
            byte_ok[k] = (pb[k] == CHAR_ANY) || (pb[k] == in_char_reg);
            if (k + 1 < PATTERN_MAX) star[k] = (k + 1 < int'(len)) && (pb[k+1] == CHAR_STAR);
            else                     star[k] = 1'b0;
        end
        anchored  = (len != '0) && (pb[0] == CHAR_ANCHOR_START);
        base      = anchored ? len_t'(1) : len_t'(0);
        tail_byte = (len != '0) ? pb[5'(len - len_t'(1))] : '0;
    end

    // Position-set step for one text byte
    always_comb begin
        link = '0;
        for (int k = 2; k <= PATTERN_MAX; k++) begin
            link[k] = star[k-2] && (k - 2 >= int'(base));
        end
        cur0 = active_reg;
        if (start_reg || !anchored) cur0[base] = 1'b1;
        cur        = closure(cur0, link);
        found_step = found_reg || cur[len];

        nxt = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (cur[k] && k >= int'(base) && k < int'(len)) begin
                if (star[k]) begin
                    if (byte_ok[k]) nxt[k] = 1'b1;
                end else if (!(k == int'(len) - 1 && pb[k] == CHAR_ANCHOR_END)) begin
                    if (byte_ok[k]) nxt[k+1] = 1'b1;
                end
            end
        end

        // End of text: empty match at the end and the end anchor
        nxt2 = nxt;
        if (!anchored) nxt2[0] = 1'b1;
        fin_set     = closure(nxt2, link);
        match_final = found_step || fin_set[len] ||
                      ((len > base) && (tail_byte == CHAR_ANCHOR_END) &&
                       fin_set[len - len_t'(1)]);
    end

    // Next state and result
    always_comb begin
        active_next    = active_reg;
        start_next     = start_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_match_next = out_match_reg;
        if (advance) begin
            if (in_last_reg) begin
                active_next    = '0;
                start_next     = 1'b1;
                found_next     = 1'b0;
                out_valid_next = 1'b1;
                out_match_next = match_final;
            end else begin
                active_next = nxt;
                start_next  = 1'b0;
                found_next  = found_step;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= '0;
            start_reg     <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            start_reg     <= start_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_match_reg <= out_match_next;
    end

endmodule

>>> bench/tb_match_checker.sv
// tb_match_checker: watches the text, result and configuration channels of the
// stream regex matcher, predicts each match verdict and compares it. Uses srsm_pkg.
`timescale 1ns / 1ps

module tb_match_checker
    import srsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   verdicts_seen,
    output int                   matches_seen
);

    // shadow configuration and NFA state
    logic [5:0]  pat_len_reg;
    logic [63:0] pat_word [WORD_COUNT];
    logic [PATTERN_MAX:0] live_pos;
    logic        text_start;
    logic        seen_match;
    bit          verdict_q [$];

    function automatic logic [7:0] pat_at(int k);
        if (k >= STORED_BYTES) return 8'h00;
        return pat_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic int used_len();
        return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
    endfunction

    function automatic bit starred(int k, int n);
        return (k + 1 < n) && (pat_at(k + 1) == CHAR_STAR);
    endfunction

    // skip over starred tokens, in order, so chains propagate
    function automatic logic [PATTERN_MAX:0] skip_stars(logic [PATTERN_MAX:0] s,
                                                         int from, int n);
        for (int k = from; k < n; k++)
            if (s[k] && starred(k, n)) s[k + 2] = 1'b1;
        return s;
    endfunction

    // one text byte: advance shadow state, push a verdict on the last byte
    task automatic take_byte(logic [7:0] c, logic lst);
        int n;
        bit anch;
        int b;
        logic [PATTERN_MAX:0] cur;
        logic [PATTERN_MAX:0] nxt;
        logic [7:0] p;
        n    = used_len();
        anch = (n > 0) && (pat_at(0) == CHAR_ANCHOR_START);
        b    = anch ? 1 : 0;
        cur  = live_pos;
        if (text_start || !anch) cur[b] = 1'b1;
        cur = skip_stars(cur, b, n);
        if (cur[n]) seen_match = 1'b1;
        nxt = '0;
        for (int k = b; k < n; k++) begin
            if (!cur[k]) continue;
            p = pat_at(k);
            if (starred(k, n)) begin
                if (p == CHAR_ANY || p == c) nxt[k] = 1'b1;
            end else if (k == n - 1 && p == CHAR_ANCHOR_END) begin
                // end anchor eats no byte
            end else if (p == CHAR_ANY || p == c) begin
                nxt[k + 1] = 1'b1;
            end
        end
        live_pos   = nxt;
        text_start = 1'b0;
        if (lst) begin
            if (!anch) nxt[b] = 1'b1;
            nxt = skip_stars(nxt, b, n);
            if (nxt[n]) seen_match = 1'b1;
            if (n > b && pat_at(n - 1) == CHAR_ANCHOR_END && nxt[n - 1]) seen_match = 1'b1;
            verdict_q.push_back(seen_match);
            live_pos   = '0;
            text_start = 1'b1;
            seen_match = 1'b0;
        end
    endtask

    assign pending = verdict_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg   = '0;
            for (int i = 0; i < WORD_COUNT; i++) pat_word[i] = '0;
            live_pos      = '0;
            text_start    = 1'b1;
            seen_match    = 1'b0;
            fail_count    <= 0;
            verdicts_seen <= 0;
            matches_seen  <= 0;
            verdict_q.delete();
        end else begin
            // result side first: compare with the oldest verdict
            if (m_tvalid && m_tready) begin
                verdicts_seen <= verdicts_seen + 1;
                if (m_tdata[0]) matches_seen <= matches_seen + 1;
                if (verdict_q.size() == 0) begin
                    $error("unexpected result item: matched=%0d", m_tdata[0]);
                    fail_count <= fail_count + 1;
                end else begin
                    bit want;
                    want = verdict_q.pop_front();
                    if (m_tdata !== {7'd0, want}) begin
                        $error("matched: expected %0d, actual %0h", want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PATTERN_LEN)
                    pat_len_reg = cfg_data[5:0];
                else if (cfg_index <= REG_PATTERN_WORD_3)
                    pat_word[2'(cfg_index - REG_PATTERN_WORD_0)] = cfg_data;
            end
        end
    end

endmodule

>>> bench/tb.sv
// tb: stimulus and verdict for simple_regex_stream_matcher_unit.
// Depends on srsm_pkg, simple_regex_stream_matcher_unit and tb_match_checker.
`timescale 1ns / 1ps

module tb;
    import srsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] text_char
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [0] matched, [7:1] zero
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    int fail_count;
    int pending;
    int verdicts_seen;
    int matches_seen;
    int idle_cycles = 0;
    int bytes_sent;
    int patterns_used;
    bit stall_free;

    simple_regex_stream_matcher_unit u_dut (.*);

    tb_match_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver stall pattern: shifting feedback mask with occasional free stretches
    logic [15:0] stall_mask;
    always @(negedge aclk) begin
        if (!aresetn) begin
            stall_mask <= 16'hB3C5;
            m_tready   <= 1'b0;
        end else begin
            stall_mask <= {stall_mask[14:0], stall_mask[15] ^ stall_mask[13]};
            m_tready   <= stall_free | stall_mask[0] | stall_mask[3];
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // load a pattern; idle block only
    task automatic load_pattern(logic [5:0] n, logic [7:0] pb [32]);
        logic [63:0] w;
        drain();
        for (int i = 0; i < WORD_COUNT; i++) begin
            for (int j = 0; j < 8; j++) w[j * 8 +: 8] = pb[i * 8 + j];
            write_reg(CFG_IDX_W'(int'(REG_PATTERN_WORD_0) + i), w);
        end
        write_reg(REG_PATTERN_LEN, 64'(n));
        cfg_valid <= 1'b0;
        patterns_used++;
    endtask

    // send one byte; holds valid across burst when gap is zero
    task automatic send_byte(logic [7:0] c, logic lst, int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // small alphabet so patterns actually match
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return CHAR_ANY;
            1:       return CHAR_STAR;
            2:       return CHAR_ANCHOR_END;
            3:       return CHAR_ANCHOR_START;
            9:       return 8'($urandom);
            default: return 8'h61 + 8'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_text(int tlen, bit busy);
        logic [7:0] c;
        int gap;
        for (int i = 0; i < tlen; i++) begin
            c = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h61 + 8'($urandom_range(0, 2));
            gap = (!busy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            send_byte(c, i == tlen - 1, gap);
        end
    endtask

    logic [7:0] pb [32];

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        stall_free = 1'b0;
        bytes_sent = 0; patterns_used = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty pattern, then extremes of text bytes
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'hFF, 1'b0, 1);
        send_byte(8'hAA, 1'b1, 0);
        // "^a.*b$"
        foreach (pb[i]) pb[i] = 8'h00;
        pb[0] = CHAR_ANCHOR_START; pb[1] = 8'h61; pb[2] = CHAR_ANY;
        pb[3] = CHAR_STAR; pb[4] = 8'h62; pb[5] = CHAR_ANCHOR_END;
        load_pattern(6'd6, pb);
        send_byte(8'h61, 1'b0, 0); send_byte(8'h55, 1'b0, 0); send_byte(8'h62, 1'b1, 0);
        send_byte(8'h62, 1'b0, 0); send_byte(8'h61, 1'b0, 0); send_byte(8'h62, 1'b1, 2);
        // lone star literal, and "a*" that matches empty
        foreach (pb[i]) pb[i] = 8'h00;
        pb[0] = CHAR_STAR; pb[1] = 8'h61; pb[2] = CHAR_STAR;
        load_pattern(6'd3, pb);
        send_byte(CHAR_STAR, 1'b1, 0); send_byte(8'h62, 1'b1, 0);
        // all-ones words, length beyond max (63) is clamped to 32
        foreach (pb[i]) pb[i] = 8'hFF;
        load_pattern(6'd63, pb);
        for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7, 0);
        // full 32-byte "a*" chain with end anchor
        for (int i = 0; i < 32; i++) pb[i] = (i % 2) ? CHAR_STAR : 8'h61;
        pb[31] = CHAR_ANCHOR_END;
        load_pattern(6'd32, pb);
        send_byte(8'h61, 1'b0, 0); send_byte(8'h61, 1'b1, 0);
        // unknown register indexes are ignored
        drain();
        write_reg(CFG_IDX_W'(int'(REG_PATTERN_WORD_3) + 1), 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg('1, 64'h0);
        cfg_valid <= 1'b0;

        // random phases
        while (bytes_sent < 1010) begin
            int plen;
            foreach (pb[i]) pb[i] = ($urandom_range(0, 30) == 0) ? 8'($urandom) : pick_char();
            case ($urandom_range(0, 9))
                0:       plen = 0;
                1:       plen = $urandom_range(33, 63);
                2:       plen = 32;
                default: plen = $urandom_range(1, 7);
            endcase
            if ($urandom_range(0, 5) == 0) begin
                pb[0] = CHAR_ANCHOR_START;
                for (int i = 0; i < 32; i++) pb[i] = (i == 0) ? CHAR_ANCHOR_START : 8'($urandom);
            end
            load_pattern(6'(plen), pb);
            stall_free = ($urandom_range(0, 3) == 0);
            for (int t = 0; t < $urandom_range(3, 8); t++) begin
                bit busy;
                busy = ($urandom_range(0, 2) == 0);
                send_text($urandom_range(1, 12), busy);
                if ($urandom_range(0, 4) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge aclk);
                end
                if ($urandom_range(0, 9) == 0) begin
                    s_tvalid <= 1'b0;
                    do @(negedge aclk); while (pending != 0);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        $display("covered %0d text bytes over %0d patterns", bytes_sent, patterns_used);
        $display("%0d verdicts checked, %0d of them matches", verdicts_seen, matches_seen);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
